FILE: hw/rtl/pcd_pkg.sv
// ---------------------------------------------------------------------------
// pcd_pkg: page cache directory shared definitions
// Opcodes, status codes, the entry record, the cell command and the
// sequencer states used by the directory's cells, top level and checker.
// ---------------------------------------------------------------------------
package pcd_pkg;

	localparam int STREAM_W = 8;
	localparam int PAGE_W   = 40;
	localparam int HANDLE_W = 16;
	localparam int TMARK_W  = 48;
	localparam int MASK_W   = 32;
	localparam int STATUS_W = 2;
	localparam int OP_W     = 4;
	localparam int CAP_W    = 7;
	localparam int OCC_OUT_W = 7;

	localparam int MAX_ENTRIES_DEF  = 64;
	localparam int SECTORS_PER_PAGE = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

	// sector bits kept for a stored page
	localparam logic [MASK_W-1:0] MASK_LIMIT = (SECTORS_PER_PAGE >= MASK_W) ?
		{MASK_W{1'b1}} : MASK_W'((64'd1 << SECTORS_PER_PAGE) - 64'd1);

	localparam logic [OP_W-1:0] OP_LOOKUP      = OP_W'(0);
	localparam logic [OP_W-1:0] OP_EXISTS      = OP_W'(1);
	localparam logic [OP_W-1:0] OP_INS_CLEAN   = OP_W'(2);
	localparam logic [OP_W-1:0] OP_INS_DIRTY   = OP_W'(3);
	localparam logic [OP_W-1:0] OP_UPDATE      = OP_W'(4);
	localparam logic [OP_W-1:0] OP_MARK_WB     = OP_W'(5);
	localparam logic [OP_W-1:0] OP_REMOVE      = OP_W'(6);
	localparam logic [OP_W-1:0] OP_EVICT_LRU   = OP_W'(7);
	localparam logic [OP_W-1:0] OP_EVICT_DIRTY = OP_W'(8);

	localparam logic [STATUS_W-1:0] ST_EMPTY = STATUS_W'(0);
	localparam logic [STATUS_W-1:0] ST_CLEAN = STATUS_W'(1);
	localparam logic [STATUS_W-1:0] ST_DIRTY = STATUS_W'(2);
	localparam logic [STATUS_W-1:0] ST_WB    = STATUS_W'(3);

	typedef struct packed {
		logic [STREAM_W-1:0] stream;
		logic [PAGE_W-1:0]   page;
		logic [HANDLE_W-1:0] handle;
		logic [TMARK_W-1:0]  tmark;
		logic [MASK_W-1:0]   mask;
		logic [STATUS_W-1:0] status;
	} entry_t;

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_LEFT,
		CMD_RIGHT,
		CMD_WB
	} cell_cmd_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MATCH,
		S_SEL,
		S_APPLY
	} state_t;

endpackage

FILE: hw/rtl/pcd_if.sv
// ---------------------------------------------------------------------------
// pcd_if: request and response channels
// Valid/ready channels carrying one request word and one response word.
// ---------------------------------------------------------------------------
interface pcd_req_if;
	logic                           valid;
	logic                           ready;
	logic [pcd_pkg::OP_W-1:0]       opcode;
	logic [pcd_pkg::STREAM_W-1:0]   stream_num;
	logic [pcd_pkg::PAGE_W-1:0]     page_addr;
	logic [pcd_pkg::HANDLE_W-1:0]   buffer_handle;
	logic [pcd_pkg::TMARK_W-1:0]    time_mark;
	logic [pcd_pkg::MASK_W-1:0]     sector_mask;

	modport source (output valid, opcode, stream_num, page_addr, buffer_handle,
		time_mark, sector_mask, input ready);
	modport sink (input valid, opcode, stream_num, page_addr, buffer_handle,
		time_mark, sector_mask, output ready);
endinterface

interface pcd_rsp_if;
	logic                           valid;
	logic                           ready;
	logic                           hit;
	logic [pcd_pkg::STATUS_W-1:0]   entry_status;
	logic [pcd_pkg::STREAM_W-1:0]   out_stream;
	logic [pcd_pkg::PAGE_W-1:0]     out_page;
	logic [pcd_pkg::HANDLE_W-1:0]   out_handle;
	logic [pcd_pkg::TMARK_W-1:0]    out_time;
	logic [pcd_pkg::MASK_W-1:0]     out_mask;
	logic [pcd_pkg::OCC_OUT_W-1:0]  occupancy;
	logic                           full_res;

	modport source (output valid, hit, entry_status, out_stream, out_page, out_handle,
		out_time, out_mask, occupancy, full_res, input ready);
	modport sink (input valid, hit, entry_status, out_stream, out_page, out_handle,
		out_time, out_mask, occupancy, full_res, output ready);
endinterface

FILE: hw/rtl/pcd_cell.sv
// ---------------------------------------------------------------------------
// pcd_cell: one slot of the recency chain
// Holds one entry; compares it against the request key and shifts toward
// either neighbor or marks itself for writeback on command.
// ---------------------------------------------------------------------------
module pcd_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         match_en,
	input  logic [pcd_pkg::STREAM_W-1:0] key_stream,
	input  logic [pcd_pkg::PAGE_W-1:0]   key_page,
	input  pcd_pkg::cell_cmd_t           cmd,
	input  logic                         left_valid,
	input  pcd_pkg::entry_t              left_entry,
	input  logic                         right_valid,
	input  pcd_pkg::entry_t              right_entry,
	output logic                         valid,
	output pcd_pkg::entry_t              entry,
	output logic                         match,
	output logic                         dirty
);

	logic            valid_q;
	pcd_pkg::entry_t entry_q;
	logic            match_q;
	logic            dirty_q;

	// valid bit follows the shift direction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (cmd)
				pcd_pkg::CMD_LEFT:  valid_q <= left_valid;
				pcd_pkg::CMD_RIGHT: valid_q <= right_valid;
				default:            valid_q <= valid_q;
			endcase
		end
	end

	// payload shifts or takes the writeback status
	always_ff @(posedge clk) begin
		unique case (cmd)
			pcd_pkg::CMD_LEFT:  entry_q <= left_entry;
			pcd_pkg::CMD_RIGHT: entry_q <= right_entry;
			pcd_pkg::CMD_WB:    entry_q.status <= pcd_pkg::ST_WB;
			default:            entry_q <= entry_q;
		endcase
	end

	// capture key compare and dirty flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
			dirty_q <= 1'b0;
		end else if (match_en) begin
			match_q <= valid_q && entry_q.stream == key_stream && entry_q.page == key_page;
			dirty_q <= valid_q && entry_q.status == pcd_pkg::ST_DIRTY;
		end
	end

	assign valid = valid_q;
	assign entry = entry_q;
	assign match = match_q;
	assign dirty = dirty_q;

endmodule

FILE: hw/rtl/ssd_page_cache_lru_dirty_unit.sv
// ---------------------------------------------------------------------------
// ssd_page_cache_lru_dirty_unit: fully associative LRU page cache directory
// Entries live in a row of cells kept in recency order, most recent in
// cell 0, valid entries packed at the low end. Lookup and update hits move
// to the front, drops close the gap, inserts of a new key push the row back by one.
//
//   channel | dir | handshake     | word
//   req     | in  | valid/ready   | opcode, key, handle, time, sector mask
//   rsp     | out | valid/ready   | hit, status, entry fields, occupancy
//   cfg     | in  | cfg_we        | capacity_pages
//
// An item passes through the sequencer states idle/accept, key match, select,
// apply; the busy states are the sequencer steps over the cell row.
// A new word is accepted once the response register is empty or draining.
// Reset clears all cell valid bits and the count at once; no clearing pass.
// A stalled response holds the block in idle.
// ---------------------------------------------------------------------------
module ssd_page_cache_lru_dirty_unit #(
	parameter int MAX_ENTRIES = pcd_pkg::MAX_ENTRIES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	pcd_req_if.sink                   req,
	pcd_rsp_if.source                 rsp,
	input  logic                      cfg_we,
	input  logic [pcd_pkg::CAP_W-1:0] cfg_wdata
);

	localparam int N     = MAX_ENTRIES;
	localparam int OCC_W = $clog2(N + 1);
	localparam int CW    = (OCC_W > pcd_pkg::CAP_W) ? OCC_W : pcd_pkg::CAP_W;

	pcd_pkg::state_t state_q, state_d;

	logic [pcd_pkg::CAP_W-1:0]    cap_q;
	logic [OCC_W-1:0]             occ_q, occ_d;
	logic [pcd_pkg::OP_W-1:0]     op_q;
	logic [pcd_pkg::STREAM_W-1:0] stream_q;
	logic [pcd_pkg::PAGE_W-1:0]   page_q;
	logic [pcd_pkg::HANDLE_W-1:0] handle_q;
	logic [pcd_pkg::TMARK_W-1:0]  tmark_q;
	logic [pcd_pkg::MASK_W-1:0]   mask_q;

	pcd_pkg::cell_cmd_t cmd_q [N];
	pcd_pkg::cell_cmd_t cmd_d [N];
	pcd_pkg::entry_t    front_q, front_d;
	pcd_pkg::entry_t    res_q, res_d;
	logic               hit_q, hit_d;
	logic               report_d;

	logic [N-1:0]    vld, match, dirty;
	pcd_pkg::entry_t ent [N];

	logic [N-1:0]    sel, lru_sel, dirty_last, suf_match, pre_sel;
	pcd_pkg::entry_t sel_ent;
	logic            any_dirty, full_now;
	logic [CW-1:0]   eff_cap;

	logic              out_v_q;
	logic              out_hit_q;
	pcd_pkg::entry_t   out_ent_q;
	logic [OCC_W-1:0]  out_occ_q;
	logic              out_full_q;

	logic accept, match_en;

	assign accept   = req.valid && req.ready;
	assign match_en = state_q == pcd_pkg::S_MATCH;
	assign req.ready = state_q == pcd_pkg::S_IDLE && (!out_v_q || rsp.ready);

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= pcd_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// effective capacity: zero reads as one, clamp to the row length
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CW'(1);
		end else if (CW'(cap_q) > CW'(N)) begin
			eff_cap = CW'(N);
		end else begin
			eff_cap = CW'(cap_q);
		end
	end

	// hold the request word
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= req.opcode;
			stream_q <= req.stream_num;
			page_q   <= req.page_addr;
			handle_q <= req.buffer_handle;
			tmark_q  <= req.time_mark;
			mask_q   <= req.sector_mask & pcd_pkg::MASK_LIMIT;
		end
	end

	// cell row
	for (genvar i = 0; i < N; i++) begin : g_cell
		logic                 lv, rv;
		pcd_pkg::entry_t      le, re;
		if (i == 0) begin : g_head
			assign lv = 1'b1;
			assign le = front_q;
		end else begin : g_mid
			assign lv = vld[i-1];
			assign le = ent[i-1];
		end
		if (i == N - 1) begin : g_tail
			assign rv = 1'b0;
			assign re = ent[i];
		end else begin : g_body
			assign rv = vld[i+1];
			assign re = ent[i+1];
		end
		pcd_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.match_en    (match_en),
			.key_stream  (stream_q),
			.key_page    (page_q),
			.cmd         (cmd_q[i]),
			.left_valid  (lv),
			.left_entry  (le),
			.right_valid (rv),
			.right_entry (re),
			.valid       (vld[i]),
			.entry       (ent[i]),
			.match       (match[i]),
			.dirty       (dirty[i])
		);
	end

	// locate LRU cell, last dirty cell and the suffix of the match
	always_comb begin
		for (int i = 0; i < N; i++) begin
			lru_sel[i]    = vld[i] && ((i == N - 1) || !vld[(i + 1) % N]);
			dirty_last[i] = dirty[i] && !(|(dirty >> (i + 1)));
			suf_match[i]  = |(match >> i);
		end
		any_dirty = |dirty;
		full_now  = CW'(occ_q) >= eff_cap;
	end

	// choose the entry to report or move
	always_comb begin
		priority if (op_q == pcd_pkg::OP_EVICT_LRU) begin
			sel = lru_sel;
		end else if (op_q == pcd_pkg::OP_EVICT_DIRTY) begin
			sel = any_dirty ? dirty_last : lru_sel;
		end else begin
			sel = match;
		end
		for (int i = 0; i < N; i++) begin
			pre_sel[i] = |(sel << (N - 1 - i));
		end
		sel_ent = '0;
		for (int i = 0; i < N; i++) begin
			sel_ent = sel_ent | (sel[i] ? ent[i] : '0);
		end
	end

	// decode the operation into per-cell commands and the result
	always_comb begin
		for (int i = 0; i < N; i++) begin
			cmd_d[i] = pcd_pkg::CMD_HOLD;
		end
		front_d  = sel_ent;
		hit_d    = 1'b0;
		report_d = 1'b0;
		occ_d    = occ_q;
		res_d    = sel_ent;
		unique case (op_q)
			pcd_pkg::OP_LOOKUP: begin
				hit_d    = |match;
				report_d = |match;
				for (int i = 0; i < N; i++) begin
					if (suf_match[i]) cmd_d[i] = pcd_pkg::CMD_LEFT;
				end
			end
			pcd_pkg::OP_EXISTS: begin
				hit_d = |match;
			end
			pcd_pkg::OP_INS_CLEAN, pcd_pkg::OP_INS_DIRTY: begin
				hit_d          = |match;
				front_d.stream = stream_q;
				front_d.page   = page_q;
				front_d.handle = handle_q;
				front_d.tmark  = tmark_q;
				front_d.mask   = mask_q;
				front_d.status = (op_q == pcd_pkg::OP_INS_CLEAN) ?
					pcd_pkg::ST_CLEAN : pcd_pkg::ST_DIRTY;
				if (!(|match)) begin
					for (int i = 0; i < N; i++) begin
						if (!full_now || vld[i]) cmd_d[i] = pcd_pkg::CMD_LEFT;
					end
					if (!full_now) occ_d = occ_q + OCC_W'(1);
				end
			end
			pcd_pkg::OP_UPDATE: begin
				hit_d          = |match;
				front_d.handle = handle_q;
				front_d.tmark  = tmark_q;
				front_d.mask   = mask_q;
				front_d.status = pcd_pkg::ST_DIRTY;
				for (int i = 0; i < N; i++) begin
					if (suf_match[i]) cmd_d[i] = pcd_pkg::CMD_LEFT;
				end
			end
			pcd_pkg::OP_MARK_WB: begin
				hit_d = |match;
				for (int i = 0; i < N; i++) begin
					if (match[i]) cmd_d[i] = pcd_pkg::CMD_WB;
				end
			end
			pcd_pkg::OP_REMOVE, pcd_pkg::OP_EVICT_LRU, pcd_pkg::OP_EVICT_DIRTY: begin
				hit_d    = |sel;
				report_d = (op_q != pcd_pkg::OP_REMOVE) && (|sel);
				if (op_q == pcd_pkg::OP_EVICT_DIRTY) begin
					res_d.status = any_dirty ? pcd_pkg::ST_DIRTY : pcd_pkg::ST_EMPTY;
				end
				for (int i = 0; i < N; i++) begin
					if (pre_sel[i]) cmd_d[i] = pcd_pkg::CMD_RIGHT;
				end
				if (|sel) occ_d = occ_q - OCC_W'(1);
			end
			default: begin
				hit_d = 1'b0;
			end
		endcase
		if (!report_d) res_d = '0;
	end

	// register select results, issue cell commands for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				cmd_q[i] <= pcd_pkg::CMD_HOLD;
			end
			occ_q <= '0;
		end else begin
			for (int i = 0; i < N; i++) begin
				cmd_q[i] <= (state_q == pcd_pkg::S_SEL) ? cmd_d[i] : pcd_pkg::CMD_HOLD;
			end
			if (state_q == pcd_pkg::S_SEL) occ_q <= occ_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pcd_pkg::S_SEL) begin
			front_q <= front_d;
			res_q   <= res_d;
			hit_q   <= hit_d;
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcd_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		unique case (state_q)
			pcd_pkg::S_IDLE:  state_d = accept ? pcd_pkg::S_MATCH : pcd_pkg::S_IDLE;
			pcd_pkg::S_MATCH: state_d = pcd_pkg::S_SEL;
			pcd_pkg::S_SEL:   state_d = pcd_pkg::S_APPLY;
			pcd_pkg::S_APPLY: state_d = pcd_pkg::S_IDLE;
			default:          state_d = pcd_pkg::S_IDLE;
		endcase
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (state_q == pcd_pkg::S_APPLY) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pcd_pkg::S_APPLY) begin
			out_hit_q  <= hit_q;
			out_ent_q  <= res_q;
			out_occ_q  <= occ_q;
			out_full_q <= CW'(occ_q) >= eff_cap;
		end
	end

	assign rsp.valid        = out_v_q;
	assign rsp.hit          = out_hit_q;
	assign rsp.entry_status = out_ent_q.status;
	assign rsp.out_stream   = out_ent_q.stream;
	assign rsp.out_page     = out_ent_q.page;
	assign rsp.out_handle   = out_ent_q.handle;
	assign rsp.out_time     = out_ent_q.tmark;
	assign rsp.out_mask     = out_ent_q.mask;
	assign rsp.occupancy    = pcd_pkg::OCC_OUT_W'(out_occ_q);
	assign rsp.full_res     = out_full_q;

endmodule

FILE: hw/rtl/pcd_chk.sv
// ---------------------------------------------------------------------------
// pcd_chk: port-level checks for the page cache directory
// Watches the request and response handshakes and the response word.
// ---------------------------------------------------------------------------
module pcd_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [pcd_pkg::OCC_OUT_W-1:0]   occupancy,
	input logic                            full_res
);

	// a response follows every accepted word once the sequencer has passed match, select and apply
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##4 out_valid)
		else $error("response missing four cycles after accept");

	// one word at a time
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word accepted while busy");

	// a stalled response blocks new words
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("word accepted with response stalled");

	// capacity is at least one, so full means occupied
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && full_res |-> occupancy != '0)
		else $error("full reported with empty directory");

	// a stalled response holds its word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(occupancy) && $stable(full_res))
		else $error("stalled response changed");

endmodule

bind ssd_page_cache_lru_dirty_unit pcd_chk u_pcd_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req.valid),
	.in_ready  (req.ready),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.occupancy (rsp.occupancy),
	.full_res  (rsp.full_res)
);
